/* design/ptq_pkg.sv */
// Package for the two-class priority wait queue: sizes, widths, operation
// codes and the command types passed between the control, chain and cell.
// No dependencies.
`timescale 1ns / 1ps

package ptq_pkg;

    localparam int FLOORS      = 8;
    localparam int QUEUE_DEPTH = 64;
    localparam int DEPART_MAX  = 15;

    localparam int FLOOR_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int POS_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the request and result.
    localparam int FUNC_W  = 2;
    localparam int FLOOR_F = 3;
    localparam int COUNT_W = 4;
    localparam int SIZE_W  = 7;
    localparam int WAIT_W  = 16;
    localparam int SUM_W   = 32;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 80;

    typedef enum logic [FUNC_W-1:0] {
        OP_ARRIVE = 2'd0,
        OP_DEPART = 2'd1,
        OP_TICK   = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // Command for one floor's chain.
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_SHIFT,
        CH_AGE
    } chain_op_t;

    typedef struct packed {
        chain_op_t        op;
        logic [POS_W-1:0] pos;   // insert position
    } chain_cmd_t;

    // Per-cell action.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ZERO,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_AGE
    } cell_op_t;

endpackage

/* design/ptq_cell.sv */
// One queue slot: a 16-bit wait that can be cleared, aged, or loaded
// from either neighbor. Depends on ptq_pkg.
`timescale 1ns / 1ps

module ptq_cell (
    input  logic                         aclk,
    input  ptq_pkg::cell_op_t            op,
    input  logic [ptq_pkg::WAIT_W-1:0]   left_wait,
    input  logic [ptq_pkg::WAIT_W-1:0]   right_wait,
    output logic [ptq_pkg::WAIT_W-1:0]   wait_out
);

    logic [ptq_pkg::WAIT_W-1:0] wait_reg;
    logic [ptq_pkg::WAIT_W-1:0] wait_next;

    always_comb begin
        unique case (op)
            ptq_pkg::CELL_ZERO:  wait_next = '0;
            ptq_pkg::CELL_LEFT:  wait_next = left_wait;
            ptq_pkg::CELL_RIGHT: wait_next = right_wait;
            ptq_pkg::CELL_AGE:   wait_next = (wait_reg == '1) ? wait_reg
                                                              : wait_reg + 1'b1;
            default:             wait_next = wait_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        wait_reg <= wait_next;
    end

    assign wait_out = wait_reg;

endmodule

/* design/ptq_chain.sv */
// One floor's queue as a row of cells, head at slot 0. Urgent entries sit
// ahead of normal ones, so an insert opens a gap; a serve shifts toward
// the head. Depends on ptq_pkg and ptq_cell.
`timescale 1ns / 1ps

module ptq_chain (
    input  logic                         aclk,
    input  ptq_pkg::chain_cmd_t          cmd,
    output logic [ptq_pkg::WAIT_W-1:0]   head_wait
);

    logic [ptq_pkg::WAIT_W-1:0] cell_wait [ptq_pkg::QUEUE_DEPTH];

    for (genvar i = 0; i < ptq_pkg::QUEUE_DEPTH; i++) begin : g_cell
        ptq_pkg::cell_op_t          op;
        logic [ptq_pkg::WAIT_W-1:0] left_w;
        logic [ptq_pkg::WAIT_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = cell_wait[i-1];
        end

        if (i == ptq_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_wait[i+1];
        end

        always_comb begin
            unique case (cmd.op)
                ptq_pkg::CH_INSERT: begin
                    if (ptq_pkg::POS_W'(i) > cmd.pos) begin
                        op = ptq_pkg::CELL_LEFT;
                    end else if (ptq_pkg::POS_W'(i) == cmd.pos) begin
                        op = ptq_pkg::CELL_ZERO;
                    end else begin
                        op = ptq_pkg::CELL_HOLD;
                    end
                end
                ptq_pkg::CH_SHIFT: op = ptq_pkg::CELL_RIGHT;
                ptq_pkg::CH_AGE:   op = ptq_pkg::CELL_AGE;
                default:           op = ptq_pkg::CELL_HOLD;
            endcase
        end

        ptq_cell u_cell (
            .aclk       (aclk),
            .op         (op),
            .left_wait  (left_w),
            .right_wait (right_w),
            .wait_out   (cell_wait[i])
        );
    end

    assign head_wait = cell_wait[0];

endmodule

/* design/two_class_priority_wait_queue_unit.sv */
// Two-class priority wait queue, top level: request FSM, per-floor stats,
//   one cell chain per floor.
// Flow: a request is accepted in ST_IDLE and runs in ST_EXEC; ST_RESP loads the result and
//   sets m_tvalid once the output is free. A depart serves up to k entries (k <= 15), one per cycle.
// A new request is taken only after the last result is loaded; the depart loop is the longest.
// Reset (aresetn low, synchronous): all counts, peaks and sums clear; queues are empty at once.
`timescale 1ns / 1ps

module two_class_priority_wait_queue_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request: [1:0] func, [4:2] floor, [5] urgent, [9:6] count, [15:10] zero
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptq_pkg::S_DATA_W-1:0]    s_tdata,
    // result: [6:0] queue_size, [13:7] peak_size, [45:14] total_wait,
    //         [77:46] served_total, [78] status, [79] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptq_pkg::M_DATA_W-1:0]    m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,   // one step of the operation per cycle
        ST_RESP    // load the result register
    } state_t;

    state_t                          state_reg;
    ptq_pkg::op_t                    op_reg;
    logic [ptq_pkg::FLOOR_F-1:0]     floor_reg;
    logic                            urgent_reg;
    logic [ptq_pkg::COUNT_W-1:0]     rem_reg;      // entries still to serve
    logic                            dropped_reg;
    logic                            m_tvalid_reg;
    logic [ptq_pkg::M_DATA_W-1:0]    m_tdata_reg;

    // Per-floor bookkeeping.
    logic [ptq_pkg::OCC_W-1:0]  u_occ_reg  [ptq_pkg::FLOORS];
    logic [ptq_pkg::OCC_W-1:0]  n_occ_reg  [ptq_pkg::FLOORS];
    logic [ptq_pkg::OCC_W-1:0]  peak_reg   [ptq_pkg::FLOORS];
    logic [ptq_pkg::SUM_W-1:0]  wsum_reg   [ptq_pkg::FLOORS];
    logic [ptq_pkg::SUM_W-1:0]  served_reg [ptq_pkg::FLOORS];

    logic [ptq_pkg::WAIT_W-1:0] head_wait  [ptq_pkg::FLOORS];
    ptq_pkg::chain_cmd_t        floor_cmd  [ptq_pkg::FLOORS];

    logic                       req_accept;
    logic                       floor_ok;
    logic [ptq_pkg::FLOOR_W-1:0] fidx;
    logic [ptq_pkg::OCC_W-1:0]  cur_u;
    logic [ptq_pkg::OCC_W-1:0]  cur_n;
    logic [ptq_pkg::OCC_W-1:0]  cur_size;
    logic [ptq_pkg::OCC_W-1:0]  cur_peak;
    logic [ptq_pkg::SUM_W-1:0]  cur_wsum;
    logic [ptq_pkg::SUM_W-1:0]  cur_served;
    logic [ptq_pkg::WAIT_W-1:0] cur_head;
    logic                       not_full;
    logic                       serve_step;
    logic [ptq_pkg::SUM_W:0]    wsum_add;
    logic [ptq_pkg::SUM_W-1:0]  wsum_next;
    logic [ptq_pkg::SUM_W-1:0]  served_next;
    logic [ptq_pkg::OCC_W-1:0]  size_next;
    ptq_pkg::chain_cmd_t        cmd;
    logic                       out_free;
    logic [ptq_pkg::COUNT_W-1:0] s_count_clamped;

    assign req_accept = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_count_clamped = (int'(s_tdata[9:6]) > ptq_pkg::DEPART_MAX)
                           ? ptq_pkg::COUNT_W'(ptq_pkg::DEPART_MAX) : s_tdata[9:6];

    // Floor lookup for the request in flight.
    assign floor_ok   = int'(floor_reg) < ptq_pkg::FLOORS;
    assign fidx       = ptq_pkg::FLOOR_W'(floor_reg);
    assign cur_u      = u_occ_reg[fidx];
    assign cur_n      = n_occ_reg[fidx];
    assign cur_size   = ptq_pkg::OCC_W'(cur_u + cur_n);
    assign cur_peak   = peak_reg[fidx];
    assign cur_wsum   = wsum_reg[fidx];
    assign cur_served = served_reg[fidx];
    assign cur_head   = head_wait[fidx];
    assign not_full   = int'(cur_size) < ptq_pkg::QUEUE_DEPTH;
    assign size_next  = ptq_pkg::OCC_W'(cur_size + 1'b1);

    // Serve one head entry this cycle.
    assign serve_step = (state_reg == ST_EXEC) && floor_ok
                     && (op_reg == ptq_pkg::OP_DEPART)
                     && (rem_reg != '0) && (cur_size != '0);

    // Saturating statistics.
    assign wsum_add    = {1'b0, cur_wsum} + {{(ptq_pkg::SUM_W + 1 - ptq_pkg::WAIT_W){1'b0}},
                                             cur_head};
    assign wsum_next   = wsum_add[ptq_pkg::SUM_W] ? '1 : wsum_add[ptq_pkg::SUM_W-1:0];
    assign served_next = (cur_served == '1) ? cur_served : cur_served + 1'b1;

    // Command for the addressed chain.
    always_comb begin
        cmd.op  = ptq_pkg::CH_HOLD;
        cmd.pos = '0;
        if (state_reg == ST_EXEC && floor_ok) begin
            unique case (op_reg)
                ptq_pkg::OP_ARRIVE: begin
                    if (not_full) begin
                        cmd.op  = ptq_pkg::CH_INSERT;
                        // urgent goes right behind the last urgent entry
                        cmd.pos = urgent_reg ? ptq_pkg::POS_W'(cur_u)
                                             : ptq_pkg::POS_W'(cur_size);
                    end
                end
                ptq_pkg::OP_DEPART: begin
                    if (serve_step) begin
                        cmd.op = ptq_pkg::CH_SHIFT;
                    end
                end
                ptq_pkg::OP_TICK: cmd.op = ptq_pkg::CH_AGE;
                default:          cmd.op = ptq_pkg::CH_HOLD;
            endcase
        end
    end

    for (genvar f = 0; f < ptq_pkg::FLOORS; f++) begin : g_floor
        assign floor_cmd[f] = (fidx == ptq_pkg::FLOOR_W'(f)) ? cmd
                            : ptq_pkg::chain_cmd_t'{op: ptq_pkg::CH_HOLD, pos: '0};

        ptq_chain u_chain (
            .aclk      (aclk),
            .cmd       (floor_cmd[f]),
            .head_wait (head_wait[f])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= ptq_pkg::OP_QUERY;
            floor_reg    <= '0;
            urgent_reg   <= 1'b0;
            rem_reg      <= '0;
            dropped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int f = 0; f < ptq_pkg::FLOORS; f++) begin
                u_occ_reg[f]  <= '0;
                n_occ_reg[f]  <= '0;
                peak_reg[f]   <= '0;
                wsum_reg[f]   <= '0;
                served_reg[f] <= '0;
            end
        end else begin
            // in ST_RESP the result register load below decides m_tvalid
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (req_accept) begin
                        op_reg      <= ptq_pkg::op_t'(s_tdata[1:0]);
                        floor_reg   <= s_tdata[4:2];
                        urgent_reg  <= s_tdata[5];
                        rem_reg     <= s_count_clamped;
                        dropped_reg <= 1'b0;
                        state_reg   <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    if (!floor_ok) begin
                        state_reg <= ST_RESP;
                    end else begin
                        unique case (op_reg)
                            ptq_pkg::OP_ARRIVE: begin
                                if (not_full) begin
                                    if (urgent_reg) begin
                                        u_occ_reg[fidx] <= ptq_pkg::OCC_W'(cur_u + 1'b1);
                                    end else begin
                                        n_occ_reg[fidx] <= ptq_pkg::OCC_W'(cur_n + 1'b1);
                                    end
                                    if (size_next > cur_peak) begin
                                        peak_reg[fidx] <= size_next;
                                    end
                                end else begin
                                    dropped_reg <= 1'b1;
                                end
                                state_reg <= ST_RESP;
                            end
                            ptq_pkg::OP_DEPART: begin
                                if (serve_step) begin
                                    wsum_reg[fidx]   <= wsum_next;
                                    served_reg[fidx] <= served_next;
                                    rem_reg          <= rem_reg - 1'b1;
                                    if (cur_u != '0) begin
                                        u_occ_reg[fidx] <= cur_u - 1'b1;
                                    end else begin
                                        n_occ_reg[fidx] <= cur_n - 1'b1;
                                    end
                                end else begin
                                    state_reg <= ST_RESP;
                                end
                            end
                            default: state_reg <= ST_RESP;
                        endcase
                    end
                end

                ST_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (floor_ok) begin
                            m_tdata_reg <= {1'b0, dropped_reg, cur_served, cur_wsum,
                                            ptq_pkg::SIZE_W'(cur_peak),
                                            ptq_pkg::SIZE_W'(cur_size)};
                        end else begin
                            m_tdata_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Combined occupancy never exceeds the queue depth.
    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        floor_ok |-> (int'(cur_size) <= ptq_pkg::QUEUE_DEPTH))
        else $error("floor occupancy above queue depth");

    // The recorded peak always covers the current size.
    a_peak_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        floor_ok |-> (cur_peak >= cur_size))
        else $error("peak below current size");

    // Each serve step uses up one entry of the depart budget.
    a_serve_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        serve_step |=> (rem_reg == $past(rem_reg) - 1'b1))
        else $error("depart budget not decremented");

    // A serve step removes exactly one entry from the floor.
    a_serve_size: assert property (@(posedge aclk) disable iff (!aresetn)
        serve_step |=> (cur_size == $past(cur_size) - 1'b1))
        else $error("serve did not remove one entry");
`endif

endmodule
